FILE: design/tqv_pkg.sv
package tqv_pkg;

   localparam int MAX_DIVISIONS = 256;
   localparam int ANGLE_BITS    = 16;
   localparam int IDX_W         = 8;
   localparam int REG_W         = 16;
   localparam int POS_W         = 16;
   localparam int TURN_W        = 32;
   localparam int CORDIC_STEPS  = 16;
   localparam int CW            = 34;   // CORDIC datapath width
   localparam int TRIG_W        = 32;   // stored cos/sin, Q2.30
   localparam int FRAC_BITS     = 30;

   // slots of the trig buffer; power of two so the pointers wrap
   localparam int NUM_SLOTS   = 8;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int SLOT_CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int TRIG_DEPTH  = 2 * NUM_SLOTS;
   localparam int TRIG_ADDR_W = SLOT_W + 1;

   // result queue; power of two
   localparam int OFIFO_DEPTH = 8;
   localparam int OFIFO_W     = $clog2(OFIFO_DEPTH);
   localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [1:0] LAST_CORNER = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAJOR_RADIUS,
      CSR_MINOR_RADIUS,
      CSR_PHI_STEP,
      CSR_THETA_STEP
   } csr_index_type;

   typedef enum logic [1:0] {
      ANG_PHI0,
      ANG_PHI1,
      ANG_THETA0,
      ANG_THETA1
   } angle_kind_type;

   typedef struct packed {
      logic [IDX_W-1:0] ring_index;
      logic [IDX_W-1:0] section_index;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [1:0]              corner;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      angle_kind_type    kind;
   } trig_tag_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } sincos_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] corner;
   } vtx_ctl_type;

endpackage

FILE: design/tqv_ram.sv
module tqv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tqv_cordic.sv
module tqv_cordic (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  tqv_pkg::trig_tag_type       in_tag,
   input  logic [tqv_pkg::TURN_W-1:0]  in_turn,
   output logic                        out_valid,
   output tqv_pkg::trig_tag_type       out_tag,
   output tqv_pkg::sincos_type         out_sc
);
   import tqv_pkg::*;

   localparam logic signed [CW-1:0] CORDIC_GAIN  = CW'(652032874);
   localparam logic signed [CW-1:0] QUARTER_TURN = CW'(1073741824);

   // arctangent of 2^-i in 32-bit turn units
   function automatic logic signed [CW-1:0] atan_turn(input int step);
      logic signed [CW-1:0] val;
      case (step)
         0:       val = CW'(536870912);
         1:       val = CW'(316933406);
         2:       val = CW'(167458907);
         3:       val = CW'(85004756);
         4:       val = CW'(42667331);
         5:       val = CW'(21354465);
         6:       val = CW'(10679838);
         7:       val = CW'(5340245);
         8:       val = CW'(2670163);
         9:       val = CW'(1335087);
         10:      val = CW'(667544);
         11:      val = CW'(333772);
         12:      val = CW'(166886);
         13:      val = CW'(83443);
         14:      val = CW'(41722);
         15:      val = CW'(20861);
         default: val = '0;
      endcase
      return val;
   endfunction

   logic [TURN_W-1:0]    turn_alt;
   logic signed [CW-1:0] z_raw;
   logic signed [CW-1:0] z_pre;
   logic                 flip_pre;

   assign turn_alt = in_turn + {1'b1, {(TURN_W-1){1'b0}}};
   assign z_raw    = CW'($signed(in_turn));

   // past a quarter turn: rotate by half a turn, negate the result
   always_comb begin
      if (z_raw > QUARTER_TURN || z_raw < -QUARTER_TURN) begin
         z_pre    = CW'($signed(turn_alt));
         flip_pre = 1'b1;
      end else begin
         z_pre    = z_raw;
         flip_pre = 1'b0;
      end
   end

   logic                 valid_ff [CORDIC_STEPS+1];
   trig_tag_type         tag_ff   [CORDIC_STEPS+1];
   logic                 flip_ff  [CORDIC_STEPS+1];
   logic signed [CW-1:0] x_ff     [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_ff     [CORDIC_STEPS+1];
   logic signed [CW-1:0] z_ff     [CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0]  <= in_tag;
      flip_ff[0] <= flip_pre;
      x_ff[0]    <= CORDIC_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_pre;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         tag_ff[i+1]  <= tag_ff[i];
         flip_ff[i+1] <= flip_ff[i];
         if (!z_ff[i][CW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_turn(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_turn(i);
         end
      end
   end

   logic signed [CW-1:0] cos_full;
   logic signed [CW-1:0] sin_full;

   assign cos_full = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
   assign sin_full = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];

   assign out_valid      = valid_ff[CORDIC_STEPS];
   assign out_tag        = tag_ff[CORDIC_STEPS];
   assign out_sc.cos_val = TRIG_W'(cos_full);
   assign out_sc.sin_val = TRIG_W'(sin_full);

endmodule

FILE: design/tqv_vertex.sv
module tqv_vertex (
   input  logic                       clock,
   input  logic                       reset,
   input  tqv_pkg::vtx_ctl_type       in_ctl,
   input  tqv_pkg::sincos_type        phi_sc,
   input  tqv_pkg::sincos_type        theta_sc,
   input  logic [tqv_pkg::REG_W-1:0]  major_radius,
   input  logic [tqv_pkg::REG_W-1:0]  minor_radius,
   output logic                       out_valid,
   output tqv_pkg::rsp_type           out_rsp
);
   import tqv_pkg::*;

   localparam int MUL_W  = REG_W + 1 + TRIG_W;
   localparam int RHO_W  = REG_W + 4;
   localparam int PROD_W = RHO_W + TRIG_W;
   localparam int WIDE_W = PROD_W + 1;
   localparam int RND_W  = WIDE_W - FRAC_BITS;
   localparam logic signed [RND_W-1:0] POS_HI = RND_W'((1 << (POS_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] POS_LO = -POS_HI - RND_W'(1);

   // round half up out of Q.30
   function automatic logic signed [RND_W-1:0] round_q(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] t;
      t = v + (WIDE_W'(1) <<< (FRAC_BITS - 1));
      return RND_W'(t >>> FRAC_BITS);
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RND_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > POS_HI) begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end else if (v < POS_LO) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   vtx_ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;

   logic signed [MUL_W-1:0]  mr_ff, mz_ff;
   logic signed [TRIG_W-1:0] ct1_ff, st1_ff, ct2_ff, st2_ff;
   logic signed [RHO_W-1:0]  rho_ff;
   logic signed [POS_W-1:0]  z2_ff, z3_ff;
   logic signed [PROD_W-1:0] mx_ff, my_ff;
   rsp_type                  rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      // tube terms
      mr_ff  <= $signed({1'b0, minor_radius}) * phi_sc.cos_val;
      mz_ff  <= $signed({1'b0, minor_radius}) * phi_sc.sin_val;
      ct1_ff <= theta_sc.cos_val;
      st1_ff <= theta_sc.sin_val;

      // rho kept unsaturated
      rho_ff <= RHO_W'($signed({1'b0, major_radius})) + RHO_W'(round_q(WIDE_W'(mr_ff)));
      z2_ff  <= sat_pos(round_q(WIDE_W'(mz_ff)));
      ct2_ff <= ct1_ff;
      st2_ff <= st1_ff;

      mx_ff <= rho_ff * ct2_ff;
      my_ff <= rho_ff * st2_ff;
      z3_ff <= z2_ff;

      rsp_ff.pos_x  <= sat_pos(round_q(WIDE_W'(mx_ff)));
      rsp_ff.pos_y  <= sat_pos(round_q(WIDE_W'(my_ff)));
      rsp_ff.pos_z  <= z3_ff;
      rsp_ff.corner <= ctl3_ff.corner;
      rsp_ff.last   <= (ctl3_ff.corner == LAST_CORNER);
   end

   assign out_valid = ctl4_ff.valid;
   assign out_rsp   = rsp_ff;

endmodule

FILE: design/torus_quad_vertex_generator_unit.sv
// Channel   Ports                          Moves
// req       req_valid/req_ready/req_data   one quad request: ring and section index
// rsp       rsp_valid/rsp_ready/rsp_data   one vertex, four per request, corner order
// csr       csr_wr_en/csr_index/csr_wr_data  radius and angle step writes, no wait
//
// The front issues the four angles of a request into the one CORDIC pipe, one per cycle,
// and the vertex side reads one corner per cycle from the trig RAMs while a finished slot and
// result queue credit are there. A new request can be accepted while the last angle issues.
// Reset is synchronous and clears control and loads the register defaults; no clearing pass.
// rsp_ready low fills an 8-entry result queue, then trig buffer slots, then req_ready drops.
module torus_quad_vertex_generator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tqv_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tqv_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [tqv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tqv_pkg::REG_W-1:0]      csr_wr_data
);
   import tqv_pkg::*;

   // configuration
   logic [REG_W-1:0] major_radius_ff, minor_radius_ff, phi_step_ff, theta_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_radius_ff <= REG_W'(4096);
         minor_radius_ff <= REG_W'(1024);
         phi_step_ff     <= REG_W'(3277);
         theta_step_ff   <= REG_W'(3277);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAJOR_RADIUS: major_radius_ff <= csr_wr_data;
            CSR_MINOR_RADIUS: minor_radius_ff <= csr_wr_data;
            CSR_PHI_STEP:     phi_step_ff     <= csr_wr_data;
            CSR_THETA_STEP:   theta_step_ff   <= csr_wr_data;
         endcase
      end
   end

   function automatic logic [IDX_W-1:0] clamp_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] r;
      if (32'(idx) >= 32'(MAX_DIVISIONS)) begin
         r = IDX_W'(MAX_DIVISIONS - 1);
      end else begin
         r = idx;
      end
      return r;
   endfunction

   // front: one angle per cycle into the CORDIC pipe
   logic                  busy_ff, busy_in;
   angle_kind_type        kind_ff, kind_in;
   logic [IDX_W-1:0]      ring_ff, section_ff;
   logic [SLOT_W-1:0]     wslot_ff, alloc_ptr_ff, alloc_in;
   logic [SLOT_CNT_W-1:0] free_cnt_ff, free_in;
   logic                  req_fire, slot_release;

   assign req_ready = (free_cnt_ff != '0) && (!busy_ff || kind_ff == ANG_THETA1);
   assign req_fire  = req_valid && req_ready;
   assign busy_in   = req_fire || (busy_ff && kind_ff != ANG_THETA1);
   assign kind_in   = busy_ff ? angle_kind_type'(2'(kind_ff + 2'd1)) : ANG_PHI0;
   assign alloc_in  = req_fire ? SLOT_W'(alloc_ptr_ff + 1'b1) : alloc_ptr_ff;

   always_comb begin
      free_in = free_cnt_ff;
      if (req_fire) begin
         free_in = free_in - SLOT_CNT_W'(1);
      end
      if (slot_release) begin
         free_in = free_in + SLOT_CNT_W'(1);
      end
   end

   logic                    is_theta, is_next;
   logic [IDX_W-1:0]        base_idx;
   logic [IDX_W:0]          step_idx;
   logic [REG_W-1:0]        step_sel;
   logic [IDX_W+REG_W:0]    angle_prod;
   logic [TURN_W-1:0]       turn_in;

   assign is_theta   = (kind_ff == ANG_THETA0) || (kind_ff == ANG_THETA1);
   assign is_next    = (kind_ff == ANG_PHI1) || (kind_ff == ANG_THETA1);
   assign base_idx   = is_theta ? section_ff : ring_ff;
   assign step_idx   = {1'b0, base_idx} + (IDX_W+1)'(is_next);
   assign step_sel   = is_theta ? theta_step_ff : phi_step_ff;
   assign angle_prod = step_idx * step_sel;
   assign turn_in    = {angle_prod[ANGLE_BITS-1:0], {(TURN_W-ANGLE_BITS){1'b0}}};

   logic              ang_valid_ff;
   trig_tag_type      ang_tag_ff;
   logic [TURN_W-1:0] ang_turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         kind_ff      <= ANG_PHI0;
         alloc_ptr_ff <= '0;
         free_cnt_ff  <= SLOT_CNT_W'(NUM_SLOTS);
         ang_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         kind_ff      <= kind_in;
         alloc_ptr_ff <= alloc_in;
         free_cnt_ff  <= free_in;
         ang_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ring_ff    <= clamp_index(req_data.ring_index);
         section_ff <= clamp_index(req_data.section_index);
         wslot_ff   <= alloc_ptr_ff;
      end
      ang_tag_ff.slot <= wslot_ff;
      ang_tag_ff.kind <= kind_ff;
      ang_turn_ff     <= turn_in;
   end

   logic         cor_valid;
   trig_tag_type cor_tag;
   sincos_type   cor_sc;

   tqv_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid_ff),
      .in_tag    (ang_tag_ff),
      .in_turn   (ang_turn_ff),
      .out_valid (cor_valid),
      .out_tag   (cor_tag),
      .out_sc    (cor_sc)
   );

   // trig buffer: entry {slot, second angle}
   logic                   cor_theta, cor_next, phi_we, theta_we, done_inc;
   logic [TRIG_ADDR_W-1:0] wr_addr, phi_rd_addr, theta_rd_addr;
   sincos_type             phi_rd, theta_rd;

   assign cor_theta = (cor_tag.kind == ANG_THETA0) || (cor_tag.kind == ANG_THETA1);
   assign cor_next  = (cor_tag.kind == ANG_PHI1) || (cor_tag.kind == ANG_THETA1);
   assign phi_we    = cor_valid && !cor_theta;
   assign theta_we  = cor_valid && cor_theta;
   assign wr_addr   = {cor_tag.slot, cor_next};
   assign done_inc  = cor_valid && (cor_tag.kind == ANG_THETA1);

   tqv_ram #(
      .WIDTH ($bits(sincos_type)),
      .DEPTH (TRIG_DEPTH)
   ) u_phi_ram (
      .clock   (clock),
      .wr_en   (phi_we),
      .wr_addr (wr_addr),
      .wr_data (cor_sc),
      .rd_addr (phi_rd_addr),
      .rd_data (phi_rd)
   );

   tqv_ram #(
      .WIDTH ($bits(sincos_type)),
      .DEPTH (TRIG_DEPTH)
   ) u_theta_ram (
      .clock   (clock),
      .wr_en   (theta_we),
      .wr_addr (wr_addr),
      .wr_data (cor_sc),
      .rd_addr (theta_rd_addr),
      .rd_data (theta_rd)
   );

   // vertex side: one corner per cycle from a finished slot, while result queue credit remains
   logic [SLOT_CNT_W-1:0]  done_cnt_ff, done_in;
   logic [SLOT_W-1:0]      rslot_ff;
   logic [1:0]             corner_ff;
   logic [OFIFO_CNT_W-1:0] out_credit_ff, credit_in;
   vtx_ctl_type            rd_ctl_ff;
   logic                   vtx_issue, rsp_pop;

   assign vtx_issue    = (done_cnt_ff != '0) && (out_credit_ff != '0);
   assign slot_release = vtx_issue && (corner_ff == LAST_CORNER);
   // corners 1 and 2 use phi+dphi, corners 2 and 3 use theta+dtheta
   assign phi_rd_addr   = {rslot_ff, corner_ff[1] ^ corner_ff[0]};
   assign theta_rd_addr = {rslot_ff, corner_ff[1]};

   always_comb begin
      done_in = done_cnt_ff;
      if (done_inc) begin
         done_in = done_in + SLOT_CNT_W'(1);
      end
      if (slot_release) begin
         done_in = done_in - SLOT_CNT_W'(1);
      end
      credit_in = out_credit_ff;
      if (vtx_issue) begin
         credit_in = credit_in - OFIFO_CNT_W'(1);
      end
      if (rsp_pop) begin
         credit_in = credit_in + OFIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_cnt_ff   <= '0;
         rslot_ff      <= '0;
         corner_ff     <= '0;
         out_credit_ff <= OFIFO_CNT_W'(OFIFO_DEPTH);
         rd_ctl_ff     <= '0;
      end else begin
         done_cnt_ff      <= done_in;
         out_credit_ff    <= credit_in;
         rd_ctl_ff.valid  <= vtx_issue;
         rd_ctl_ff.corner <= corner_ff;
         if (vtx_issue) begin
            corner_ff <= 2'(corner_ff + 2'd1);
            if (corner_ff == LAST_CORNER) begin
               rslot_ff <= SLOT_W'(rslot_ff + 1'b1);
            end
         end
      end
   end

   logic    vtx_valid;
   rsp_type vtx_rsp;

   tqv_vertex u_vertex (
      .clock        (clock),
      .reset        (reset),
      .in_ctl       (rd_ctl_ff),
      .phi_sc       (phi_rd),
      .theta_sc     (theta_rd),
      .major_radius (major_radius_ff),
      .minor_radius (minor_radius_ff),
      .out_valid    (vtx_valid),
      .out_rsp      (vtx_rsp)
   );

   // result queue, space reserved by the credit count at issue
   rsp_type                ofifo_ff [OFIFO_DEPTH];
   logic [OFIFO_W-1:0]     owr_ptr_ff, ord_ptr_ff;
   logic [OFIFO_CNT_W-1:0] ofifo_cnt_ff, ofifo_cnt_in;

   assign rsp_valid = (ofifo_cnt_ff != '0);
   assign rsp_data  = ofifo_ff[ord_ptr_ff];
   assign rsp_pop   = rsp_valid && rsp_ready;

   always_comb begin
      ofifo_cnt_in = ofifo_cnt_ff;
      if (vtx_valid) begin
         ofifo_cnt_in = ofifo_cnt_in + OFIFO_CNT_W'(1);
      end
      if (rsp_pop) begin
         ofifo_cnt_in = ofifo_cnt_in - OFIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff   <= '0;
         ord_ptr_ff   <= '0;
         ofifo_cnt_ff <= '0;
      end else begin
         ofifo_cnt_ff <= ofifo_cnt_in;
         if (vtx_valid) begin
            owr_ptr_ff <= OFIFO_W'(owr_ptr_ff + 1'b1);
         end
         if (rsp_pop) begin
            ord_ptr_ff <= OFIFO_W'(ord_ptr_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vtx_valid) begin
         ofifo_ff[owr_ptr_ff] <= vtx_rsp;
      end
   end

   // slot accounting: in flight plus finished plus free is the whole buffer
   assert property (@(posedge clock) disable iff (reset)
      (32'(done_cnt_ff) + 32'(free_cnt_ff)) <= NUM_SLOTS)
      else $error("trig buffer slot count overrun");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (free_cnt_ff < SLOT_CNT_W'(NUM_SLOTS)))
      else $error("slot taken but free count full");

   assert property (@(posedge clock) disable iff (reset)
      (32'(out_credit_ff) + 32'(ofifo_cnt_ff)) <= OFIFO_DEPTH)
      else $error("result queue credit overrun");

   assert property (@(posedge clock) disable iff (reset)
      vtx_valid |-> ((ofifo_cnt_ff != OFIFO_CNT_W'(OFIFO_DEPTH)) || rsp_pop))
      else $error("vertex written into full result queue");

endmodule
